/* hw/rtl/sv39ptw_pkg.sv */
// Package for the Sv39 page-table walker: store geometry, status and opcode codes,
// and the packed item and result types shared by the walker and its users.
// No dependencies.
`default_nettype none

package sv39ptw_pkg;

    localparam int STORE_WORDS = 4096;
    localparam int LEVELS      = 3;
    localparam int PTE_PER_PG  = 512;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int IDX_W       = $clog2(PTE_PER_PG);
    localparam int PAGE_W      = ADDR_W - IDX_W;
    localparam int STORE_PAGES = STORE_WORDS / PTE_PER_PG;
    localparam int LEVEL_W     = $clog2(LEVELS);
    localparam int CLR_W       = ADDR_W + 1;

    localparam logic [0:0] OP_WRITE     = 1'b0;
    localparam logic [0:0] OP_TRANSLATE = 1'b1;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_VA_TOO_LARGE  = 3'd1;
    localparam logic [2:0] ST_TABLE_MISSING = 3'd2;
    localparam logic [2:0] ST_LEAF_INVALID  = 3'd3;
    localparam logic [2:0] ST_NOT_USER      = 3'd4;
    localparam logic [2:0] ST_OUTSIDE_STORE = 3'd5;

    localparam int PTE_V = 0;
    localparam int PTE_U = 4;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [11:0] word_index;
        logic [63:0] write_data;
        logic [63:0] virtual_address;
    } t_item;

    typedef struct packed {
        logic [55:0] physical_page_base;
        logic [2:0]  status;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/sv39_page_table_walker_unit.sv */
// Top level of the Sv39 page-table walker: a 4096-word PTE store and the walk sequencer.
// Depends on sv39ptw_pkg for geometry, codes and the item and result types.
//
//   channel   signals                     direction  transfer
//   item      start, busy, i_item         in         edge with start high and busy low
//   result    o_done, o_result            out        edge that ends the cycle with o_done high
//   config    i_cfg_we, i_cfg_wdata       in         edge with i_cfg_we high
//
// A write or a rejected translation gives its result in the cycle after the transfer and
// leaves busy low. A translation that reaches the store holds busy through its dependent
// PTE reads from the single store read port and gives its result after the last read or
// the first fault. After reset busy stays high while the store is cleared one word a cycle;
// configuration writes are taken during that pass. The receiver cannot stall results.
`default_nettype none

module sv39_page_table_walker_unit
    import sv39ptw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_item   i_item,
    input  wire logic    i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata,
    output logic         o_done,
    output t_result      o_result
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [63:0]        r_mem [STORE_WORDS];
    logic [63:0]        r_rd_data;

    logic [1:0]         r_state, n_state;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [CLR_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic [2:0]         r_root;
    logic [17:0]        r_va_idx, n_va_idx;
    logic               r_done, n_done;
    t_result            r_result, n_result;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [63:0]        mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               accept;
    logic [IDX_W-1:0]   next_idx;
    logic               next_page_ok;
    logic               root_ok;
    logic               va_ok;

    assign accept       = start && !busy;
    assign busy         = (r_state != S_IDLE);
    assign va_ok        = (i_item.virtual_address[63:38] == '0);
    assign root_ok      = (32'(r_root) < STORE_PAGES);
    assign next_page_ok = (r_rd_data[63:10] < 54'(STORE_PAGES));
    assign next_idx     = (r_level == LEVEL_W'(2)) ? r_va_idx[17:9] : r_va_idx[8:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_clr_cnt = r_clr_cnt;
        n_va_idx  = r_va_idx;
        n_done    = 1'b0;
        n_result  = '0;
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(i_item.word_index);
        mem_wdata = i_item.write_data;
        mem_raddr = {PAGE_W'(r_root), i_item.virtual_address[38:30]};

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt[ADDR_W-1:0];
                mem_wdata = '0;
                n_clr_cnt = r_clr_cnt + CLR_W'(1);
                if (r_clr_cnt == CLR_W'(STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == OP_WRITE) begin
                        mem_we = (32'(i_item.word_index) < STORE_WORDS);
                        n_done = 1'b1;
                    end else if (!va_ok) begin
                        n_done          = 1'b1;
                        n_result.status = ST_VA_TOO_LARGE;
                    end else if (!root_ok) begin
                        n_done          = 1'b1;
                        n_result.status = ST_OUTSIDE_STORE;
                    end else begin
                        n_state  = S_CHECK;
                        n_level  = LEVEL_W'(2);
                        n_va_idx = i_item.virtual_address[29:12];
                    end
                end
            end
            S_CHECK: begin
                mem_raddr = {r_rd_data[10 +: PAGE_W], next_idx};
                if (r_level != '0) begin
                    if (!r_rd_data[PTE_V]) begin
                        n_done          = 1'b1;
                        n_result.status = ST_TABLE_MISSING;
                        n_state         = S_IDLE;
                    end else if (!next_page_ok) begin
                        n_done          = 1'b1;
                        n_result.status = ST_OUTSIDE_STORE;
                        n_state         = S_IDLE;
                    end else begin
                        n_level = r_level - LEVEL_W'(1);
                    end
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (!r_rd_data[PTE_V]) begin
                        n_result.status = ST_LEAF_INVALID;
                    end else if (!r_rd_data[PTE_U]) begin
                        n_result.status = ST_NOT_USER;
                    end else begin
                        n_result.physical_page_base = {r_rd_data[53:10], 12'b0};
                        n_result.status             = ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_level   <= '0;
            r_clr_cnt <= '0;
            r_root    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_level   <= n_level;
            r_clr_cnt <= n_clr_cnt;
            r_done    <= n_done;
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_va_idx <= n_va_idx;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.opcode == OP_TRANSLATE) && va_ok && root_ok |=> busy && !o_done)
        else $error("walk did not start after a translate transfer");

    a_fail_zero_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status != ST_OK) |-> (o_result.physical_page_base == '0))
        else $error("failed result carries a nonzero page base");

    a_walk_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && ($past(r_state) == S_CHECK) |-> o_done)
        else $error("walk ended without a result");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result given during the clearing pass");

endmodule

`default_nettype wire

/* tb/sv39_page_table_walker_unit_test.sv */
// Self-checking testbench for sv39_page_table_walker_unit: PTE store writes and Sv39 walks
// against a shadow store, with random page tables, root changes and idle bursts.
// Depends on sv39ptw_pkg for the item and result types, opcodes and status codes.
module sv39_page_table_walker_unit_test;
    import sv39ptw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 230;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [63:0] VA_LIMIT_MASK = 64'h0000_003F_FFFF_FFFF;

    typedef enum logic {
        OP_KIND_ITEM,
        OP_KIND_ROOT
    } t_op_kind;

    typedef struct {
        t_op_kind    kind;
        t_item       item;
        logic [2:0]  root;
        int unsigned gap;
    } t_pending_op;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_item      i_item      = '0;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_wdata = '0;
    logic       o_done;
    t_result    o_result;

    t_pending_op pending_ops[$];
    t_result     walk_results_q[$];
    logic [63:0] pte_mirror [STORE_WORDS];
    logic [2:0]  root_page    = '0;
    bit          idle_off     = 1'b0;
    int unsigned items_queued = 0;
    int unsigned failures     = 0;
    int unsigned cycle_count  = 0;

    sv39_page_table_walker_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_result predict_walk(input t_item it);
        t_result     res;
        logic [63:0] page;
        logic [63:0] addr;
        logic [63:0] pte;
        res = '0;
        if (it.opcode == OP_WRITE) begin
            pte_mirror[it.word_index] = it.write_data;
            return res;
        end
        if (it.virtual_address[63:38] != '0) begin
            res.status = ST_VA_TOO_LARGE;
            return res;
        end
        page = 64'(root_page);
        for (int level = LEVELS - 1; level >= 0; level--) begin
            addr = (page << 9) + ((it.virtual_address >> (12 + 9 * level)) & 64'h1FF);
            if (addr >= 64'(STORE_WORDS)) begin
                res.status = ST_OUTSIDE_STORE;
                return res;
            end
            pte = pte_mirror[addr[11:0]];
            if (level > 0) begin
                if (!pte[PTE_V]) begin
                    res.status = ST_TABLE_MISSING;
                    return res;
                end
                page = pte >> 10;
            end else begin
                if (!pte[PTE_V]) begin
                    res.status = ST_LEAF_INVALID;
                    return res;
                end
                if (!pte[PTE_U]) begin
                    res.status = ST_NOT_USER;
                    return res;
                end
                res.physical_page_base = {pte[53:10], 12'h000};
                res.status = ST_OK;
                return res;
            end
        end
        res.status = ST_LEAF_INVALID;
        return res;
    endfunction

    task automatic push_item(input logic [0:0] op, input logic [11:0] widx,
                             input logic [63:0] wdata, input logic [63:0] va);
        t_pending_op entry;
        entry.kind                 = OP_KIND_ITEM;
        entry.item.opcode          = op;
        entry.item.word_index      = widx;
        entry.item.write_data      = wdata;
        entry.item.virtual_address = va;
        entry.root                 = '0;
        entry.gap = (!idle_off && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        pending_ops.push_back(entry);
        items_queued++;
    endtask

    task automatic push_write(input logic [11:0] widx, input logic [63:0] wdata);
        push_item(OP_WRITE, widx, wdata, rand64());
    endtask

    task automatic push_translate(input logic [63:0] va);
        push_item(OP_TRANSLATE, 12'($urandom_range(0, 4095)), rand64(), va);
    endtask

    task automatic push_root(input logic [2:0] root);
        t_pending_op entry;
        entry.kind = OP_KIND_ROOT;
        entry.item = '0;
        entry.root = root;
        entry.gap  = 0;
        pending_ops.push_back(entry);
    endtask

    function automatic logic [63:0] make_pointer(input logic [63:0] page, input bit valid);
        logic [63:0] pte;
        pte = (page << 10) | 64'($urandom_range(0, 1023));
        pte[PTE_V] = valid;
        return pte;
    endfunction

    function automatic logic [63:0] far_page();
        logic [63:0] page;
        page = rand64() >> $urandom_range(13, 60);
        if (page < 64'd8) begin
            page = page + 64'd8;
        end
        return page;
    endfunction

    function automatic logic [63:0] walk_va(input logic [8:0] i2, input logic [8:0] i1,
                                            input logic [8:0] i0);
        return (64'(i2) << 30) | (64'(i1) << 21) | (64'(i0) << 12)
             | 64'($urandom_range(0, 4095));
    endfunction

    task automatic build_walk(input logic [2:0] root);
        logic [8:0]  i2;
        logic [8:0]  i1;
        logic [8:0]  i0;
        logic [63:0] p1;
        logic [63:0] p0;
        logic [63:0] leaf;
        int          fault;
        int          hops;
        i2    = 9'($urandom_range(0, 255));
        i1    = 9'($urandom_range(0, 511));
        i0    = 9'($urandom_range(0, 511));
        p1    = 64'($urandom_range(0, 7));
        p0    = 64'($urandom_range(0, 7));
        fault = $urandom_range(0, 11);
        if (fault == 8) begin
            p1 = far_page();
        end
        if (fault == 9) begin
            p0 = far_page();
        end
        push_write({root, i2}, make_pointer(p1, fault != 6));
        if (fault != 8) begin
            push_write({p1[2:0], i1}, make_pointer(p0, fault != 7));
        end
        if (fault != 8 && fault != 9) begin
            leaf = rand64();
            leaf[PTE_V] = (fault != 10);
            leaf[PTE_U] = (fault != 11);
            push_write({p0[2:0], i0}, leaf);
        end
        hops = $urandom_range(1, 2);
        repeat (hops) begin
            push_translate(walk_va(i2, i1, i0));
        end
    endtask

    task automatic add_noise(input logic [2:0] root);
        logic [63:0] va;
        case ($urandom_range(0, 3))
            0: begin
                push_write(12'($urandom_range(0, 4095)), rand64());
            end
            1: begin
                push_translate(rand64() & VA_LIMIT_MASK);
            end
            2: begin
                va = rand64();
                if (va[63:38] == '0) begin
                    va[63 - $urandom_range(0, 25)] = 1'b1;
                end
                push_translate(va);
            end
            default: begin
                push_write({root, 9'($urandom_range(0, 511))}, rand64());
            end
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        t_pending_op head;
        logic        next_start;
        t_item       next_item;
        logic        next_cfg_we;
        logic [2:0]  next_cfg_data;
        next_start    = start;
        next_item     = i_item;
        next_cfg_we   = 1'b0;
        next_cfg_data = i_cfg_wdata;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && !busy) begin
                walk_results_q.push_back(predict_walk(i_item));
                next_start = 1'b0;
            end
            if (!next_start && pending_ops.size() != 0) begin
                head = pending_ops[0];
                if (head.kind == OP_KIND_ROOT) begin
                    if (walk_results_q.size() == 0 && !o_done) begin
                        next_cfg_we   = 1'b1;
                        next_cfg_data = head.root;
                        root_page     = head.root;
                        void'(pending_ops.pop_front());
                    end
                end else if (head.gap != 0) begin
                    pending_ops[0].gap = head.gap - 1;
                end else begin
                    next_start = 1'b1;
                    next_item  = head.item;
                    void'(pending_ops.pop_front());
                end
            end
        end
        start       <= next_start;
        i_item      <= next_item;
        i_cfg_we    <= next_cfg_we;
        i_cfg_wdata <= next_cfg_data;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (walk_results_q.size() == 0) begin
                failures++;
                $display("%0t: result transfer, expected none, actual base %h status %0d",
                         $time, o_result.physical_page_base, o_result.status);
            end else begin
                want = walk_results_q.pop_front();
                if (o_result.physical_page_base !== want.physical_page_base) begin
                    failures++;
                    $display("%0t: page base mismatch, expected %h, actual %h", $time,
                             want.physical_page_base, o_result.physical_page_base);
                end
                if (o_result.status !== want.status) begin
                    failures++;
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                             want.status, o_result.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [2:0]  roots [PHASES];
        int unsigned phase_start;
        for (int w = 0; w < STORE_WORDS; w++) begin
            pte_mirror[w] = '0;
        end

        push_translate(64'h0);
        push_translate(64'h0000_0040_0000_0000);
        push_translate(64'hFFFF_FFFF_FFFF_FFFF);
        push_translate(VA_LIMIT_MASK);
        push_write(12'd0, 64'h0000_0000_0000_0401);
        push_translate(64'h0);
        push_write(12'd512, 64'h0000_0000_0000_0801);
        push_translate(64'h0);
        push_write(12'd1024, 64'hA5A5_A5A5_A5A5_A401);
        push_translate(64'h0000_0000_0000_0123);
        push_write(12'd1024, 64'hFFFF_FFFF_FFFF_FFFF);
        push_translate(64'h0000_0000_0000_0FFF);
        push_write(12'd512, 64'h0000_0000_0000_2001);
        push_translate(64'h0);
        push_write(12'd0, 64'h0000_0000_0000_040E);
        push_translate(64'h0);
        push_write(12'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_translate(64'h0);
        push_write(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
        push_write(12'd0, 64'h0);
        push_translate(64'h0);

        roots[0] = 3'd7;
        roots[1] = 3'd0;
        roots[2] = 3'd5;
        for (int p = 3; p < PHASES; p++) begin
            roots[p] = 3'($urandom_range(0, 7));
        end
        for (int p = 0; p < PHASES; p++) begin
            idle_off = (p == PHASES - 1);
            push_root(roots[p]);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_noise(roots[p]);
                end else begin
                    build_walk(roots[p]);
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_ops.size() != 0 || start || walk_results_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0 && walk_results_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/sv39ptw_pkg.sv
hw/rtl/sv39_page_table_walker_unit.sv
tb/sv39_page_table_walker_unit_test.sv
